/* design/rcd_pkg.sv */
// rcd_pkg: shared constants and types for the rsa crt decrypt block
// no dependencies
package rcd_pkg;

	localparam int PRIME_BITS_DEF = 32;
	localparam int DATA_W         = 64;
	localparam int REG_W          = 32;
	localparam int REG_IDX_W      = 2;

	localparam logic [REG_IDX_W-1:0] REG_PRIME_P = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRIME_Q = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EXP_D   = 2'd2;

	localparam logic [REG_W-1:0]  RST_PRIME_P = 32'd61;
	localparam logic [REG_W-1:0]  RST_PRIME_Q = 32'd53;
	localparam logic [DATA_W-1:0] RST_EXP_D   = 64'd2753;

	typedef struct packed {
		logic busy;
		logic bad;
	} kg_stat_t;

endpackage

/* design/rsa_crt_decrypt.sv */
// rsa_crt_decrypt: rsa decryption of one 64-bit word by the chinese remainder theorem
// depends on rcd_pkg, rcd_modred, rcd_modmul, rcd_keygen
//
// usage: write prime_p (index 0), prime_q (index 1) and private_exponent (index 2)
// through wr_en / wr_index / wr_data. each write reruns the key setup (euclid on
// p and q plus two reductions of d), during which busy is high.
// a word is taken when start is high and busy is low. the result shows on
// plain_block and key_error for one cycle with done high; it cannot be held off.
// per word, for each prime: c is reduced mod that prime, then raised to the
// reduced exponent by modular multiplies, up to two multiplies per exponent bit;
// then m2 mod p is reduced, and one multiply and a shift-add rebuild the
// word. all multiplies go through the single bit-serial modular
// multiplier. one word at a time.
// a key with p or q below two, or with p and q sharing a factor, answers in the
// next cycle with key_error high and plain_block zero.
// reset loads p = 61, q = 53, d = 2753 and starts the key setup.
module rsa_crt_decrypt import rcd_pkg::*; #(
	parameter int PRIME_BITS = PRIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [DATA_W-1:0]    cipher_block,
	output logic                 done,
	output logic [DATA_W-1:0]    plain_block,
	output logic                 key_error,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [DATA_W-1:0]    wr_data
);

	localparam int PB = PRIME_BITS;
	localparam int CW = $clog2(PB + 1);

	typedef enum logic [3:0] {
		T_IDLE, T_RED, T_PBIT, T_PW1, T_PW2, T_M2P, T_H, T_COMB, T_FIN
	} tstate_t;

	logic [REG_W-1:0]  p_reg_q, q_reg_q;
	logic [DATA_W-1:0] d_reg_q;
	logic [PB-1:0]     p, q;
	logic [PB-1:0]     exp_p, exp_q, inv_qp;
	kg_stat_t          kst;

	tstate_t           state_q;
	logic              phase_q;
	logic [DATA_W-1:0] c_q, acc_q, plain_q;
	logic [PB-1:0]     base_q, r_q, e_q, m1_q, m2_q, h_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q, err_q;
	logic              rd_go_q, mm_go_q;
	logic [DATA_W-1:0] rd_num_q;
	logic [PB-1:0]     rd_mod_q, mm_a_q, mm_b_q, mm_m_q;
	logic              rd_done, mm_done;
	logic [PB-1:0]     rd_rem, mm_res, pm;
	logic [PB:0]       diff;

	assign p = p_reg_q[PB-1:0];
	assign q = q_reg_q[PB-1:0];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_reg_q <= RST_PRIME_P;
			q_reg_q <= RST_PRIME_Q;
			d_reg_q <= RST_EXP_D;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PRIME_P: p_reg_q <= wr_data[REG_W-1:0];
				REG_PRIME_Q: q_reg_q <= wr_data[REG_W-1:0];
				REG_EXP_D:   d_reg_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	rcd_keygen #(.PB(PB)) u_keygen (
		.clk(clk), .arst_n(arst_n), .restart(wr_en), .p(p), .q(q), .d(d_reg_q),
		.exp_p(exp_p), .exp_q(exp_q), .inv_qp(inv_qp), .stat(kst)
	);

	rcd_modred #(.PB(PB)) u_red (
		.clk(clk), .arst_n(arst_n), .flush(1'b0), .go(rd_go_q),
		.num(rd_num_q), .modulus(rd_mod_q), .done(rd_done), .rem(rd_rem)
	);

	rcd_modmul #(.PB(PB)) u_mul (
		.clk(clk), .arst_n(arst_n), .go(mm_go_q), .a(mm_a_q), .b(mm_b_q),
		.m(mm_m_q), .done(mm_done), .res(mm_res)
	);

	assign pm   = phase_q ? q : p;
	assign diff = (m1_q >= rd_rem) ? ({1'b0, m1_q} - {1'b0, rd_rem})
		: ({1'b0, m1_q} + {1'b0, p} - {1'b0, rd_rem});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
			plain_q <= '0;
			rd_go_q <= 1'b0;
			mm_go_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q  <= 1'b0;
			rd_go_q <= 1'b0;
			mm_go_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start && !kst.busy) begin
						if (kst.bad) begin
							done_q  <= 1'b1;
							plain_q <= '0;
							err_q   <= 1'b1;
						end else begin
							c_q      <= cipher_block;
							phase_q  <= 1'b0;
							rd_go_q  <= 1'b1;
							rd_num_q <= cipher_block;
							rd_mod_q <= p;
							state_q  <= T_RED;
						end
					end
				end
				T_RED: begin
					if (rd_done) begin
						base_q  <= rd_rem;
						r_q     <= PB'(1);
						e_q     <= phase_q ? exp_q : exp_p;
						state_q <= T_PBIT;
					end
				end
				T_PBIT: begin
					if (e_q == '0) begin
						rd_go_q  <= 1'b1;
						if (!phase_q) begin
							m1_q     <= r_q;
							phase_q  <= 1'b1;
							rd_num_q <= c_q;
							rd_mod_q <= q;
							state_q  <= T_RED;
						end else begin
							m2_q     <= r_q;
							rd_num_q <= DATA_W'(r_q);
							rd_mod_q <= p;
							state_q  <= T_M2P;
						end
					end else if (e_q[0]) begin
						mm_go_q <= 1'b1;
						mm_a_q  <= r_q;
						mm_b_q  <= base_q;
						mm_m_q  <= pm;
						state_q <= T_PW1;
					end else begin
						mm_go_q <= 1'b1;
						mm_a_q  <= base_q;
						mm_b_q  <= base_q;
						mm_m_q  <= pm;
						state_q <= T_PW2;
					end
				end
				T_PW1: begin
					if (mm_done) begin
						r_q     <= mm_res;
						mm_go_q <= 1'b1;
						mm_a_q  <= base_q;
						mm_b_q  <= base_q;
						mm_m_q  <= pm;
						state_q <= T_PW2;
					end
				end
				T_PW2: begin
					if (mm_done) begin
						base_q  <= mm_res;
						e_q     <= e_q >> 1;
						state_q <= T_PBIT;
					end
				end
				T_M2P: begin
					if (rd_done) begin
						mm_go_q <= 1'b1;
						mm_a_q  <= diff[PB-1:0];
						mm_b_q  <= inv_qp;
						mm_m_q  <= p;
						state_q <= T_H;
					end
				end
				T_H: begin
					if (mm_done) begin
						h_q     <= mm_res;
						acc_q   <= '0;
						cnt_q   <= CW'(PB);
						state_q <= T_COMB;
					end
				end
				T_COMB: begin
					// x = m2 + q * h, shift-add msb first
					acc_q <= {acc_q[DATA_W-2:0], 1'b0}
						+ (h_q[PB-1] ? DATA_W'(q) : DATA_W'(0));
					h_q   <= {h_q[PB-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					plain_q <= acc_q + DATA_W'(m2_q);
					err_q   <= 1'b0;
					done_q  <= 1'b1;
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != T_IDLE) || kst.busy;
	assign done        = done_q;
	assign plain_block = plain_q;
	assign key_error   = err_q;

endmodule

/* design/rcd_modred.sv */
// rcd_modred: bit-serial remainder of a 64-bit word by a narrow modulus
// one dividend bit per cycle, depends on rcd_pkg
module rcd_modred import rcd_pkg::*; #(
	parameter int PB = PRIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              flush,
	input  logic              go,
	input  logic [DATA_W-1:0] num,
	input  logic [PB-1:0]     modulus,
	output logic              done,
	output logic [PB-1:0]     rem
);

	localparam int CW = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] sh_q;
	logic [PB-1:0]     m_q;
	logic [PB-1:0]     r_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [PB:0]       t;
	logic [PB:0]       t2;

	assign t  = {r_q, sh_q[DATA_W-1]};
	assign t2 = (t >= {1'b0, m_q}) ? (t - {1'b0, m_q}) : t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (flush) begin
				run_q <= 1'b0;
			end else if (go) begin
				sh_q  <= num;
				m_q   <= modulus;
				r_q   <= '0;
				cnt_q <= CW'(DATA_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				sh_q  <= {sh_q[DATA_W-2:0], 1'b0};
				r_q   <= t2[PB-1:0];
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

/* design/rcd_modmul.sv */
// rcd_modmul: bit-serial modular multiplier, a * b mod m with a, b below m
// one multiplier bit per cycle, depends on rcd_pkg
module rcd_modmul import rcd_pkg::*; #(
	parameter int PB = PRIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [PB-1:0] a,
	input  logic [PB-1:0] b,
	input  logic [PB-1:0] m,
	output logic          done,
	output logic [PB-1:0] res
);

	localparam int CW = $clog2(PB + 1);

	logic [PB-1:0] a_q;
	logic [PB-1:0] b_q;
	logic [PB-1:0] m_q;
	logic [PB-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [PB:0]   dbl;
	logic [PB:0]   dbl_r;
	logic [PB:0]   sum;
	logic [PB:0]   sum_r;

	assign dbl   = {r_q, 1'b0};
	assign dbl_r = (dbl >= {1'b0, m_q}) ? (dbl - {1'b0, m_q}) : dbl;
	assign sum   = dbl_r + {1'b0, a_q};
	assign sum_r = (sum >= {1'b0, m_q}) ? (sum - {1'b0, m_q}) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				a_q   <= a;
				b_q   <= b;
				m_q   <= m;
				r_q   <= '0;
				cnt_q <= CW'(PB);
				run_q <= 1'b1;
			end else if (run_q) begin
				b_q   <= {b_q[PB-2:0], 1'b0};
				r_q   <= b_q[PB-1] ? sum_r[PB-1:0] : dbl_r[PB-1:0];
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

/* design/rcd_keygen.sv */
// rcd_keygen: per-key values, exponents reduced mod p-1 and q-1, inverse of q mod p
// bit-serial euclid with quotient times t folded in, depends on rcd_pkg, rcd_modred
module rcd_keygen import rcd_pkg::*; #(
	parameter int PB = PRIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [PB-1:0]     p,
	input  logic [PB-1:0]     q,
	input  logic [DATA_W-1:0] d,
	output logic [PB-1:0]     exp_p,
	output logic [PB-1:0]     exp_q,
	output logic [PB-1:0]     inv_qp,
	output kg_stat_t          stat
);

	localparam int CW = $clog2(PB + 1);

	typedef enum logic [2:0] {
		K_IDLE, K_START, K_QMP, K_EUC, K_DIV, K_UPD, K_EP, K_EQ
	} kstate_t;

	kstate_t           state_q;
	logic [PB-1:0]     r0_q, r1_q, t0_q, t1_q, sh_q, rm_q, acc_q;
	logic [PB-1:0]     exp_p_q, exp_q_q, inv_q;
	logic [CW-1:0]     cnt_q;
	logic              bad_q;
	logic              rd_go_q;
	logic [DATA_W-1:0] rd_num_q;
	logic [PB-1:0]     rd_mod_q;
	logic              rd_done;
	logic [PB-1:0]     rd_rem;
	logic [PB:0]       rt, rt_r, adbl, adbl_r, asum, asum_r, tsub;
	logic              qbit;

	rcd_modred #(.PB(PB)) u_red (
		.clk(clk), .arst_n(arst_n), .flush(restart), .go(rd_go_q),
		.num(rd_num_q), .modulus(rd_mod_q), .done(rd_done), .rem(rd_rem)
	);

	assign rt     = {rm_q, sh_q[PB-1]};
	assign qbit   = (rt >= {1'b0, r1_q});
	assign rt_r   = qbit ? (rt - {1'b0, r1_q}) : rt;
	assign adbl   = {acc_q, 1'b0};
	assign adbl_r = (adbl >= {1'b0, p}) ? (adbl - {1'b0, p}) : adbl;
	assign asum   = adbl_r + {1'b0, t1_q};
	assign asum_r = (asum >= {1'b0, p}) ? (asum - {1'b0, p}) : asum;
	assign tsub   = (t0_q >= acc_q) ? ({1'b0, t0_q} - {1'b0, acc_q})
		: ({1'b0, t0_q} + {1'b0, p} - {1'b0, acc_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_START;
			bad_q   <= 1'b1;
			rd_go_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			rd_go_q <= 1'b0;
			if (restart) begin
				state_q <= K_START;
			end else begin
				unique case (state_q)
					K_IDLE: begin
					end
					K_START: begin
						if (p < PB'(2) || q < PB'(2)) begin
							bad_q   <= 1'b1;
							state_q <= K_IDLE;
						end else begin
							rd_go_q  <= 1'b1;
							rd_num_q <= DATA_W'(q);
							rd_mod_q <= p;
							state_q  <= K_QMP;
						end
					end
					K_QMP: begin
						if (rd_done) begin
							r0_q    <= p;
							r1_q    <= rd_rem;
							t0_q    <= '0;
							t1_q    <= PB'(1);
							state_q <= K_EUC;
						end
					end
					K_EUC: begin
						if (r1_q == '0) begin
							if (r0_q == PB'(1)) begin
								inv_q    <= t0_q;
								rd_go_q  <= 1'b1;
								rd_num_q <= d;
								rd_mod_q <= p - PB'(1);
								state_q  <= K_EP;
							end else begin
								bad_q   <= 1'b1;
								state_q <= K_IDLE;
							end
						end else begin
							sh_q    <= r0_q;
							rm_q    <= '0;
							acc_q   <= '0;
							cnt_q   <= CW'(PB);
							state_q <= K_DIV;
						end
					end
					K_DIV: begin
						sh_q  <= {sh_q[PB-2:0], 1'b0};
						rm_q  <= rt_r[PB-1:0];
						acc_q <= qbit ? asum_r[PB-1:0] : adbl_r[PB-1:0];
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= K_UPD;
						end
					end
					K_UPD: begin
						r0_q    <= r1_q;
						r1_q    <= rm_q;
						t0_q    <= t1_q;
						t1_q    <= tsub[PB-1:0];
						state_q <= K_EUC;
					end
					K_EP: begin
						if (rd_done) begin
							exp_p_q  <= rd_rem;
							rd_go_q  <= 1'b1;
							rd_num_q <= d;
							rd_mod_q <= q - PB'(1);
							state_q  <= K_EQ;
						end
					end
					K_EQ: begin
						if (rd_done) begin
							exp_q_q <= rd_rem;
							bad_q   <= 1'b0;
							state_q <= K_IDLE;
						end
					end
					default: state_q <= K_IDLE;
				endcase
			end
		end
	end

	assign exp_p     = exp_p_q;
	assign exp_q     = exp_q_q;
	assign inv_qp    = inv_q;
	assign stat.busy = (state_q != K_IDLE) || restart;
	assign stat.bad  = bad_q;

endmodule
